/* src/pso_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pso_pkg;

  // Swarm geometry.
  localparam int NUM_PARTICLES = 16;
  localparam int MAX_DIMS      = 8;
  localparam int DIM_W         = 3;
  localparam int PART_W        = 4;
  localparam int ADDR_W        = PART_W + DIM_W;
  localparam int DEPTH         = NUM_PARTICLES * MAX_DIMS;
  localparam int CNT_W         = 4;

  // Fixed-point constants.
  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  // Configuration register reset values.
  localparam logic [15:0] INERTIA_RST   = 16'd11469;
  localparam logic [15:0] COGNITIVE_RST = 16'd24576;
  localparam logic [15:0] SOCIAL_RST    = 16'd24576;
  localparam logic [3:0]  DIMS_RST      = 4'd8;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_EVAL = 2'd1,
    FUNC_MOVE = 2'd2,
    FUNC_READ = 2'd3
  } pso_func_e;

  typedef enum logic [1:0] {
    REG_INERTIA   = 2'd0,
    REG_COGNITIVE = 2'd1,
    REG_SOCIAL    = 2'd2,
    REG_DIMS      = 2'd3
  } pso_reg_e;

  typedef enum logic [1:0] {
    OSEL_EVAL = 2'd0,
    OSEL_MOVE = 2'd1,
    OSEL_READ = 2'd2
  } pso_osel_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [3:0]         particle_index;
    logic [2:0]         dim_index;
    logic signed [31:0] coord_value;
    logic signed [31:0] fitness_current;
    logic signed [31:0] fitness_personal;
    logic signed [31:0] fitness_global;
    logic [15:0]        rand_personal;
    logic [15:0]        rand_social;
  } pso_in_t;

  typedef struct packed {
    logic signed [31:0] coord_out;
    logic [2:0]         dim_out;
    logic               personal_updated;
    logic               global_updated;
    logic               last;
  } pso_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             latch;
    logic             load_wr;
    logic             rd_en;
    logic             ev_wr;
    logic             mv_k;
    logic             mv_diff;
    logic             mv_mul;
    logic             mv_sum;
    logic             mv_wr;
    logic             out_load;
    pso_osel_e        out_sel;
    logic [DIM_W-1:0] dim;
    logic             last;
  } pso_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             out_free;
    logic [CNT_W-1:0] n_active;
  } pso_sts_t;

endpackage

`default_nettype wire

/* src/pso_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module pso_ctrl import pso_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire pso_in_t  in_item_i,
  output logic          in_stall_o,
  input  wire pso_sts_t sts_i,
  output pso_cmd_t      cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_EV_SWP  = 9'b000000010,
    S_EV_EMIT = 9'b000000100,
    S_MV_K    = 9'b000001000,
    S_MV_RD   = 9'b000010000,
    S_MV_DIFF = 9'b000100000,
    S_MV_MUL  = 9'b001000000,
    S_MV_SUM  = 9'b010000000,
    S_EMIT    = 9'b100000000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             is_read_q, is_read_d;
  logic             accept;
  logic             in_range;
  logic             at_last;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_range   = int'(in_item_i.particle_index) < NUM_PARTICLES;
  assign at_last    = (cnt_q == sts_i.n_active - CNT_W'(1));

  // Next state and command decode.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    is_read_d = is_read_q;
    cmd_o     = '0;
    cmd_o.out_sel = OSEL_EVAL;
    cmd_o.dim  = cnt_q[DIM_W-1:0];
    cmd_o.last = at_last;
    case (state_q)
      S_IDLE: begin
        cmd_o.latch = accept;
        cnt_d = '0;
        if (accept) begin
          if (in_item_i.func == FUNC_READ) begin
            is_read_d = 1'b1;
            state_d   = S_EMIT;
          end else if (in_range) begin
            case (in_item_i.func)
              FUNC_LOAD: cmd_o.load_wr = 1'b1;
              FUNC_EVAL: state_d = S_EV_SWP;
              FUNC_MOVE: begin
                is_read_d = 1'b0;
                state_d   = S_MV_K;
              end
              default: ;
            endcase
          end
        end
      end
      // Read one row entry per cycle and write back the previous one.
      S_EV_SWP: begin
        cmd_o.rd_en = (cnt_q < CNT_W'(MAX_DIMS));
        cmd_o.ev_wr = (cnt_q != '0);
        if (cnt_q == CNT_W'(MAX_DIMS)) begin
          state_d = S_EV_EMIT;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_EV_EMIT: begin
        cmd_o.out_sel = OSEL_EVAL;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_MV_K: begin
        cmd_o.mv_k = 1'b1;
        state_d = S_MV_RD;
      end
      S_MV_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d = S_MV_DIFF;
      end
      S_MV_DIFF: begin
        cmd_o.mv_diff = 1'b1;
        state_d = S_MV_MUL;
      end
      S_MV_MUL: begin
        cmd_o.mv_mul = 1'b1;
        state_d = S_MV_SUM;
      end
      S_MV_SUM: begin
        cmd_o.mv_sum = 1'b1;
        state_d = S_EMIT;
      end
      // One result per coordinate, for both move and read.
      S_EMIT: begin
        cmd_o.out_sel = is_read_q ? OSEL_READ : OSEL_MOVE;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.mv_wr    = !is_read_q;
          if (at_last) begin
            state_d = S_IDLE;
          end else begin
            cnt_d   = cnt_q + CNT_W'(1);
            state_d = is_read_q ? S_EMIT : S_MV_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Controller registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      is_read_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      is_read_q <= is_read_d;
    end
  end

endmodule

`default_nettype wire

/* src/pso_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module pso_dpath import pso_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire pso_in_t     in_item_i,
  input  wire pso_cmd_t    cmd_i,
  output pso_sts_t         sts_o,
  input  wire logic        out_stall_i,
  output logic             out_valid_o,
  output pso_out_t         out_item_o
);

  // Configuration registers.
  logic [15:0] w_q, c1_q, c2_q;
  logic [3:0]  dims_q;

  // Stores; an entry whose valid bit is clear reads as its reset value.
  logic signed [31:0] pos_mem [DEPTH];
  logic signed [31:0] vel_mem [DEPTH];
  logic signed [31:0] pb_mem  [DEPTH];
  logic [DEPTH-1:0]         ent_vld_q;
  logic [NUM_PARTICLES-1:0] row_vld_q;
  logic signed [31:0] gb_q [MAX_DIMS];

  // Latched item.
  logic [PART_W-1:0] p_q;
  logic [15:0]       r1_q, r2_q;
  logic              pu_q, gu_q;

  // Read data.
  logic signed [31:0] pos_rd_q, vel_rd_q, pb_rd_q;
  logic               ent_rd_vld_q, row_rd_vld_q;
  logic [DIM_W-1:0]   rd_dim_q;
  logic signed [31:0] x, v, pb, ev_val;

  // Arithmetic pipeline.
  logic [15:0]        k1_q, k2_q;
  logic [31:0]        k1_prod, k2_prod;
  logic signed [32:0] dp_q, dg_q;
  logic signed [31:0] v_q;
  logic signed [48:0] pv_q;
  logic signed [49:0] pp_q, pg_q;
  logic signed [37:0] vsum;
  logic signed [31:0] nv_q, nv_d;
  logic signed [32:0] xsum;
  logic signed [31:0] nx;

  logic [ADDR_W-1:0] rd_addr, ev_addr, ld_addr;
  logic              out_valid_q;
  pso_out_t          out_q;
  logic [CNT_W-1:0]  n_act;

  // Active coordinate count: zero acts as one, capped at the row length.
  always_comb begin
    if (dims_q == '0) begin
      n_act = CNT_W'(1);
    end else if (int'(dims_q) > MAX_DIMS) begin
      n_act = CNT_W'(MAX_DIMS);
    end else begin
      n_act = dims_q;
    end
  end

  assign sts_o.n_active = n_act;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign rd_addr = {p_q, cmd_i.dim};
  assign ev_addr = {p_q, rd_dim_q};
  assign ld_addr = {in_item_i.particle_index, in_item_i.dim_index};

  assign x      = ent_rd_vld_q ? pos_rd_q : '0;
  assign v      = ent_rd_vld_q ? vel_rd_q : ONE_Q16;
  assign pb     = row_rd_vld_q ? pb_rd_q : '0;
  assign ev_val = pu_q ? x : pb;

  assign k1_prod = c1_q * r1_q;
  assign k2_prod = c2_q * r2_q;

  // Velocity sum with floor shifts, then the position update, both saturated.
  always_comb begin
    vsum = 38'(pv_q >>> 14) + 38'(pp_q >>> 14) + 38'(pg_q >>> 14);
    if (vsum > 38'(SAT_MAX)) begin
      nv_d = SAT_MAX;
    end else if (vsum < 38'(SAT_MIN)) begin
      nv_d = SAT_MIN;
    end else begin
      nv_d = vsum[31:0];
    end
    xsum = 33'(x) + 33'(nv_q);
    if (xsum > 33'(SAT_MAX)) begin
      nx = SAT_MAX;
    end else if (xsum < 33'(SAT_MIN)) begin
      nx = SAT_MIN;
    end else begin
      nx = xsum[31:0];
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q    <= INERTIA_RST;
      c1_q   <= COGNITIVE_RST;
      c2_q   <= SOCIAL_RST;
      dims_q <= DIMS_RST;
    end else if (cfg_we_i) begin
      case (pso_reg_e'(cfg_index_i))
        REG_INERTIA:   w_q    <= cfg_wdata_i;
        REG_COGNITIVE: c1_q   <= cfg_wdata_i;
        REG_SOCIAL:    c2_q   <= cfg_wdata_i;
        REG_DIMS:      dims_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Latch the item and the comparison results at the transfer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      p_q  <= in_item_i.particle_index;
      r1_q <= in_item_i.rand_personal;
      r2_q <= in_item_i.rand_social;
      pu_q <= in_item_i.fitness_current < in_item_i.fitness_personal;
      gu_q <= in_item_i.fitness_current < in_item_i.fitness_global;
    end
  end

  // Position and velocity memories: one write port, one registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr) begin
      pos_mem[ld_addr] <= in_item_i.coord_value;
      vel_mem[ld_addr] <= ONE_Q16;
    end else if (cmd_i.mv_wr) begin
      pos_mem[rd_addr] <= nx;
      vel_mem[rd_addr] <= nv_q;
    end
    if (cmd_i.rd_en) begin
      pos_rd_q <= pos_mem[rd_addr];
      vel_rd_q <= vel_mem[rd_addr];
    end
  end

  // Personal best memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ev_wr && pu_q) begin
      pb_mem[ev_addr] <= x;
    end
    if (cmd_i.rd_en) begin
      pb_rd_q <= pb_mem[rd_addr];
    end
  end

  // Valid bits, read flags and the global best.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q    <= '0;
      row_vld_q    <= '0;
      ent_rd_vld_q <= 1'b0;
      row_rd_vld_q <= 1'b0;
      rd_dim_q     <= '0;
      for (int i = 0; i < MAX_DIMS; i++) begin
        gb_q[i] <= '0;
      end
    end else begin
      if (cmd_i.load_wr) begin
        ent_vld_q[ld_addr] <= 1'b1;
      end else if (cmd_i.mv_wr) begin
        ent_vld_q[rd_addr] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        ent_rd_vld_q <= ent_vld_q[rd_addr];
        row_rd_vld_q <= row_vld_q[p_q];
        rd_dim_q     <= cmd_i.dim;
      end
      if (cmd_i.ev_wr && pu_q) begin
        row_vld_q[p_q] <= 1'b1;
      end
      if (cmd_i.ev_wr && gu_q) begin
        gb_q[rd_dim_q] <= ev_val;
      end
    end
  end

  // Velocity rule pipeline: gains, differences, products, sum.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mv_k) begin
      k1_q <= k1_prod[31:16];
      k2_q <= k2_prod[31:16];
    end
    if (cmd_i.mv_diff) begin
      dp_q <= 33'(pb) - 33'(x);
      dg_q <= 33'(gb_q[cmd_i.dim]) - 33'(x);
      v_q  <= v;
    end
    if (cmd_i.mv_mul) begin
      pv_q <= $signed({1'b0, w_q}) * v_q;
      pp_q <= $signed({1'b0, k1_q}) * dp_q;
      pg_q <= $signed({1'b0, k2_q}) * dg_q;
    end
    if (cmd_i.mv_sum) begin
      nv_q <= nv_d;
    end
  end

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      case (cmd_i.out_sel)
        OSEL_EVAL: begin
          out_q.coord_out        <= '0;
          out_q.dim_out          <= '0;
          out_q.personal_updated <= pu_q;
          out_q.global_updated   <= gu_q;
          out_q.last             <= 1'b1;
        end
        OSEL_MOVE: begin
          out_q.coord_out        <= nx;
          out_q.dim_out          <= cmd_i.dim;
          out_q.personal_updated <= 1'b0;
          out_q.global_updated   <= 1'b0;
          out_q.last             <= cmd_i.last;
        end
        default: begin
          out_q.coord_out        <= gb_q[cmd_i.dim];
          out_q.dim_out          <= cmd_i.dim;
          out_q.personal_updated <= 1'b0;
          out_q.global_updated   <= 1'b0;
          out_q.last             <= cmd_i.last;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

/* src/particle_swarm_update.sv */
`timescale 1ns / 1ps
`default_nettype none

// Particle swarm update engine in signed Q16.16 fixed point.
// Items arrive on the input channel (in_valid_i / in_stall_o); results leave
// on the output channel (out_valid_o / out_stall_i). A transfer happens at a
// clock edge where valid is high and stall is low.
// Gains and the coordinate count are written through cfg_we_i, cfg_index_i
// and cfg_wdata_i; the user must write them only while the block is idle,
// since the block itself does not enforce it. One item is worked on at a
// time. A load gives no result. An evaluate sweeps the whole row through the
// memory read port and gives one result. A read gives one result per cycle
// while the receiver does not stall. A move first computes the gains, then
// runs each coordinate through read, difference, multiply and sum registers.
// Results sit in an output register; the next item is taken while the last
// result still waits. While the receiver stalls, the engine holds before each
// result. Reset sets the gains, count and global best to their defaults; the
// positions, velocities and personal bests read as their reset values at once
// through per-entry and per-row valid bits, so no clearing pass is needed.

module particle_swarm_update import pso_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire pso_in_t     in_item_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output pso_out_t         out_item_o
);

  pso_cmd_t cmd;
  pso_sts_t sts;

  pso_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pso_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
